// ===== rtl/core/tcs_pkg.sv =====
`default_nettype none

package tcs_pkg;

    localparam int CFG_W     = 11;
    localparam int ACC_W     = 16;
    localparam int ACC_DEPTH = 1;
    localparam int TROW_LSB  = 12;
    localparam int TEX_SIZE  = 8;
    localparam int TEX_IDX_W = 9;
    localparam int MAX_DIM   = 1024;
    localparam int ADDR_W    = 20;
    localparam int RGB_W     = 16;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST = 11'd320;
    localparam logic [CFG_W-1:0] VIEW_ROWS_RST    = 11'd240;

    typedef enum logic {
        CFG_SCREEN_WIDTH = 1'b0,
        CFG_VIEW_ROWS    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic        column_first;
        logic [9:0]  pixel_col;
        logic [9:0]  pixel_row;
        logic [2:0]  texel_col;
        logic [2:0]  texture_select;
        logic [15:0] row_step;
        logic [8:0]  shade_amount;
        logic [15:0] fog_rgb;
        logic [8:0]  fog_amount;
    } t_in_item;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] frame_address;
        logic [RGB_W-1:0]  pixel_rgb;
    } t_out_item;

    typedef struct packed {
        logic             wr;
        logic             first;
        logic [ACC_W-1:0] step;
    } t_acc_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/tcs_ram.sv =====
`default_nettype none

module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/tcs_row_acc.sv =====
`default_nettype none

module tcs_row_acc import tcs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_acc_ctl         i_ctl,
    output logic      [ACC_W-1:0] o_acc
);

    logic [ACC_W-1:0] rd_data;
    logic [ACC_W-1:0] acc_stored;
    logic [ACC_W-1:0] n_acc;
    logic             r_written;
    logic             r_fwd_valid;
    logic [ACC_W-1:0] r_fwd_data;

    tcs_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr),
        .i_waddr ('0),
        .i_wdata (n_acc),
        .i_raddr ('0),
        .o_rdata (rd_data)
    );

    // The read port still shows the old value in the cycle after a write: forward it.
    always_comb begin
        if (!r_written) begin
            acc_stored = '0;
        end else if (r_fwd_valid) begin
            acc_stored = r_fwd_data;
        end else begin
            acc_stored = rd_data;
        end
        o_acc = i_ctl.first ? '0 : acc_stored;
        n_acc = o_acc + i_ctl.step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= i_ctl.wr;
            if (i_ctl.wr) begin
                r_written <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_fwd_data <= n_acc;
        end
    end

    a_acc_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr |=> acc_stored == $past(n_acc))
        else $error("row accumulator lost its update");

endmodule

`default_nettype wire

// ===== rtl/core/tcs_color.sv =====
`default_nettype none

module tcs_color import tcs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic [TEX_IDX_W-1:0] i_tex_idx,
    input  wire logic [8:0]           i_shade,
    input  wire logic [15:0]          i_fog,
    input  wire logic [8:0]           i_famt,
    output logic      [RGB_W-1:0]     o_rgb
);

    localparam int TEX_ENTRIES = 7 * TEX_SIZE * TEX_SIZE;

    localparam logic [15:0] TEX_ROM [TEX_ENTRIES] = '{
        // grass
        16'h23c5,16'h2c46,16'h2c65,16'h2c45,16'h3ca5,16'h3ca5,16'h3485,16'h23e5,
        16'h3465,16'h3465,16'h2c45,16'h2c25,16'h3485,16'h2c45,16'h3485,16'h2c65,
        16'h3485,16'h3ca5,16'h3485,16'h3465,16'h2c45,16'h2c65,16'h2c45,16'h2c45,
        16'h3485,16'h2c45,16'h3485,16'h2c65,16'h2c45,16'h2c65,16'h2c45,16'h3465,
        16'h3465,16'h3cc5,16'h2c45,16'h2405,16'h2c45,16'h2c45,16'h2c65,16'h3465,
        16'h2c65,16'h2c45,16'h3465,16'h3465,16'h3485,16'h2c45,16'h2c45,16'h3465,
        16'h2c45,16'h2c45,16'h2425,16'h2425,16'h3485,16'h2c45,16'h3485,16'h2c45,
        16'h1bc5,16'h2c45,16'h2c65,16'h2c65,16'h2c45,16'h2c65,16'h2c65,16'h2405,
        // dirt
        16'h6a44,16'h6a44,16'h6204,16'h6204,16'h6a04,16'h7245,16'h7245,16'h6a04,
        16'h6a44,16'h59c3,16'h59c3,16'h6a24,16'h6a45,16'h7a86,16'h7265,16'h7225,
        16'h6a24,16'h6204,16'h6204,16'h6204,16'h6204,16'h6a24,16'h6a24,16'h6a04,
        16'h6204,16'h6224,16'h6a04,16'h6204,16'h59c2,16'h6203,16'h6a04,16'h6a04,
        16'h6a24,16'h7245,16'h7245,16'h7a86,16'h6a24,16'h6a24,16'h6204,16'h6204,
        16'h7265,16'h7286,16'h6a24,16'h7265,16'h6a24,16'h6224,16'h59c3,16'h59c3,
        16'h6a24,16'h61e3,16'h61c3,16'h6a04,16'h6224,16'h6224,16'h59e3,16'h59e3,
        16'h6a24,16'h61e3,16'h61e3,16'h6a04,16'h6224,16'h6224,16'h6224,16'h6224,
        // stone
        16'h8c71,16'h8c71,16'h94b2,16'h7bef,16'h528a,16'h9cd3,16'h8c51,16'h8c71,
        16'h8c71,16'h9cd3,16'h9cf3,16'h8430,16'h52aa,16'ha514,16'h9492,16'h94b2,
        16'h94b2,16'h9cf3,16'h9cf3,16'h8430,16'h528a,16'ha514,16'h94b2,16'h9cd3,
        16'h7bef,16'h8410,16'h8430,16'h738e,16'h4228,16'h8430,16'h7bef,16'h8410,
        16'h52aa,16'h5acb,16'h5acb,16'h4a49,16'h3186,16'h52aa,16'h4a69,16'h528a,
        16'h9cd3,16'had55,16'had55,16'h8c71,16'h52aa,16'ha534,16'h94b2,16'h9cd3,
        16'h8c71,16'h94b2,16'h9cd3,16'h8410,16'h4a69,16'h94b2,16'h8c51,16'h8c71,
        16'h9492,16'h9cd3,16'h9cf3,16'h8430,16'h4a69,16'h9cd3,16'h8c71,16'h8c71,
        // quartz
        16'h4207,16'h840f,16'h83ee,16'h6b4c,16'h4228,16'h840f,16'h7bae,16'h7bce,
        16'h840f,16'hffff,16'hffdd,16'hd6b9,16'h8c2f,16'hffff,16'hf77c,16'hf79c,
        16'h83ee,16'hffdd,16'hef7c,16'hce57,16'h840f,16'hffdd,16'hef3b,16'hef5c,
        16'h6b4c,16'hd6b9,16'hce58,16'had54,16'h736d,16'hd699,16'hc617,16'hce37,
        16'h4228,16'h8c2f,16'h840f,16'h736d,16'h4a48,16'h8c50,16'h83ee,16'h840f,
        16'h840f,16'hffff,16'hffdd,16'hd699,16'h8c50,16'hfffe,16'hf79c,16'hf7bc,
        16'h7bce,16'hf77c,16'he71b,16'hc617,16'h83ee,16'hf79c,16'hdef9,16'he71a,
        16'h7bce,16'hf79d,16'hef3b,16'hc637,16'h840f,16'hf7bc,16'he71a,16'he73a,
        // glass
        16'h4228,16'h8c71,16'h7c10,16'h8430,16'h8430,16'h8430,16'h8430,16'h8430,
        16'h8c71,16'hffff,16'hffff,16'hffff,16'hffff,16'hffff,16'hffff,16'hffff,
        16'h8410,16'hffff,16'hef9e,16'hf7be,16'hf7be,16'hf7be,16'hf7be,16'hf7be,
        16'h8430,16'hffff,16'hf7be,16'hf7df,16'hf7df,16'hf7df,16'hf7df,16'hf7df,
        16'h8430,16'hffff,16'hf7be,16'hf7df,16'hf7df,16'hf7ff,16'hf7ff,16'hf7ff,
        16'h8430,16'hffff,16'hf7be,16'hf7df,16'hf7ff,16'hf7ff,16'hf7ff,16'hf7ff,
        16'h8430,16'hffff,16'hf7be,16'hf7df,16'hf7ff,16'hf7ff,16'hf7ff,16'hf7ff,
        16'h8430,16'hffff,16'hf7be,16'hf7df,16'hf7ff,16'hf7ff,16'hf7ff,16'hf7ff,
        // terracotta
        16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,
        16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,
        16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,
        16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,
        16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,
        16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,
        16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,
        16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,16'h5bef,
        // water
        16'h5d5a,16'h5d5a,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,
        16'h5d5a,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,
        16'h5d5b,16'h5d5b,16'h5d5a,16'h5d5a,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,
        16'h5d5b,16'h5d5b,16'h5d5a,16'h5d5a,16'h5d5a,16'h5d5b,16'h5d5b,16'h5d5b,
        16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,
        16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,
        16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,
        16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b,16'h5d5b
    };

    localparam logic [5:0] MAX5 = 6'h1F;
    localparam logic [5:0] MAX6 = 6'h3F;

    function automatic logic [5:0] shade_chan(input logic [5:0] c, input logic [8:0] s,
                                              input logic [5:0] m);
        logic [14:0] p;
        p = {9'b0, c} * {6'b0, s};
        return (p[14:8] > {1'b0, m}) ? m : p[13:8];
    endfunction

    // floor(a + (b - a) * f / 256), clamped to [0, m]
    function automatic logic [5:0] fog_chan(input logic [5:0] a, input logic [5:0] b,
                                            input logic [8:0] f, input logic [5:0] m);
        logic signed [6:0]  d;
        logic signed [16:0] p;
        logic signed [17:0] t;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        t = $signed({4'b0, a, 8'b0}) + $signed({p[16], p});
        if (t[17]) begin
            return '0;
        end
        return (t[16:8] > {3'b0, m}) ? m : t[13:8];
    endfunction

    logic [15:0] r_b_texel;
    logic [8:0]  r_b_shade;
    logic [15:0] r_b_fog;
    logic [8:0]  r_b_famt;
    logic [5:0]  r_c_r;
    logic [5:0]  r_c_g;
    logic [5:0]  r_c_b;
    logic [15:0] r_c_fog;
    logic [8:0]  r_c_famt;
    logic [RGB_W-1:0] r_rgb;
    logic [RGB_W-1:0] n_rgb;
    logic [5:0]  fog_r;
    logic [5:0]  fog_g;
    logic [5:0]  fog_b;

    always_comb begin
        fog_r = fog_chan(r_c_r, {1'b0, r_c_fog[15:11]}, r_c_famt, MAX5);
        fog_g = fog_chan(r_c_g, r_c_fog[10:5], r_c_famt, MAX6);
        fog_b = fog_chan(r_c_b, {1'b0, r_c_fog[4:0]}, r_c_famt, MAX5);
        if (r_c_famt == '0) begin
            n_rgb = {r_c_r[4:0], r_c_g, r_c_b[4:0]};
        end else begin
            n_rgb = {fog_r[4:0], fog_g, fog_b[4:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_texel <= TEX_ROM[i_tex_idx];
            r_b_shade <= i_shade;
            r_b_fog   <= i_fog;
            r_b_famt  <= i_famt;
            r_c_r     <= shade_chan({1'b0, r_b_texel[15:11]}, r_b_shade, MAX5);
            r_c_g     <= shade_chan(r_b_texel[10:5], r_b_shade, MAX6);
            r_c_b     <= shade_chan({1'b0, r_b_texel[4:0]}, r_b_shade, MAX5);
            r_c_fog   <= r_b_fog;
            r_c_famt  <= r_b_famt;
            r_rgb     <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

    a_no_fog_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_c_famt == '0) |=> r_rgb == $past({r_c_r[4:0], r_c_g, r_c_b[4:0]}))
        else $error("shaded colour altered without fog");

endmodule

`default_nettype wire

// ===== rtl/core/textured_column_shader.sv =====
`default_nettype none

// Textured wall-column shader. One pixel transaction per clock in steady state; a result
// passes from the input register, which takes it at the accepting edge, through the
// texture ROM read, shade multiply, and fog blend into the output register, and the
// whole pipeline holds while the output is stalled. The texture-row accumulator lives
// in a one-entry memory with a registered read; a forwarding register bridges
// back-to-back updates, so no interlock stall occurs. Write the width and
// visible-row registers only while no pixel is in flight.
module textured_column_shader import tcs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_index       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_screen_width;
    logic [CFG_W-1:0] r_view_rows;

    logic     en;
    logic     r_a_valid;
    t_in_item r_a;
    logic     r_b_valid;
    logic     r_c_valid;
    logic     r_d_valid;
    logic     r_b_we;
    logic     r_c_we;
    logic     r_d_we;
    logic [ADDR_W-1:0] r_b_addr;
    logic [ADDR_W-1:0] r_c_addr;
    logic [ADDR_W-1:0] r_d_addr;

    t_acc_ctl               acc_ctl;
    logic [ACC_W-1:0]       acc_use;
    logic                   col_ok;
    logic                   row_ok;
    logic                   we_a;
    logic [20:0]            addr_full;
    logic [ADDR_W-1:0]      addr_a;
    logic [2:0]             sel_m1;
    logic [TEX_IDX_W-1:0]   tex_idx;
    logic [RGB_W-1:0]       rgb;

    assign en          = !r_d_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_d_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= SCREEN_WIDTH_RST;
            r_view_rows    <= VIEW_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_data;
                CFG_VIEW_ROWS:    r_view_rows    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        acc_ctl.wr    = en && r_a_valid;
        acc_ctl.first = r_a.column_first;
        acc_ctl.step  = r_a.row_step;
    end

    tcs_row_acc u_row_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .o_acc   (acc_use)
    );

    // Off screen when at or beyond the register value or at or beyond the hard limit.
    always_comb begin
        col_ok    = ({1'b0, r_a.pixel_col} < r_screen_width)
                 && ({3'b0, r_a.pixel_col} < 13'(MAX_DIM));
        row_ok    = ({1'b0, r_a.pixel_row} < r_view_rows)
                 && ({3'b0, r_a.pixel_row} < 13'(MAX_DIM));
        we_a      = col_ok && row_ok && (r_a.texture_select != '0);
        addr_full = 21'(r_a.pixel_row * r_screen_width) + {11'b0, r_a.pixel_col};
        addr_a    = we_a ? addr_full[ADDR_W-1:0] : '0;
        sel_m1    = r_a.texture_select - 3'd1;
        tex_idx   = we_a ? {sel_m1, acc_use[TROW_LSB+2:TROW_LSB], r_a.texel_col} : '0;
    end

    tcs_color u_color (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_tex_idx (tex_idx),
        .i_shade   (r_a.shade_amount),
        .i_fog     (r_a.fog_rgb),
        .i_famt    (r_a.fog_amount),
        .o_rgb     (rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a      <= i_in;
            r_b_we   <= r_a_valid && we_a;
            r_b_addr <= addr_a;
            r_c_we   <= r_b_we;
            r_c_addr <= r_b_addr;
            r_d_we   <= r_c_we;
            r_d_addr <= r_c_addr;
        end
    end

    always_comb begin
        o_out.write_enable  = r_d_we;
        o_out.frame_address = r_d_addr;
        o_out.pixel_rgb     = r_d_we ? rgb : '0;
    end

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.write_enable)
            |-> (o_out.frame_address == '0 && o_out.pixel_rgb == '0))
        else $error("disabled write carries nonzero payload");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_a_valid) |=> r_b_valid)
        else $error("transaction dropped between stages");

endmodule

`default_nettype wire
